FILE: hw/rtl/spc3_pkg.sv
package spc3_pkg;

   // default frame store limits
   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int MAX_HEIGHT_DEFAULT = 1024;

   // field widths fixed by the stream format
   localparam int PIXEL_W = 32;
   localparam int COORD_W = 10;
   localparam int CLASS_W = 3;
   localparam int CFG_W   = 11;

   // stream payload widths, padded to whole bytes
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 24;

   localparam logic [PIXEL_W-1:0] WHITE_PIXEL = 32'hffff_ffff;

   // window shift keeps columns 0 and 1 of each row after the shift
   localparam logic [8:0] WIN_KEEP_MASK = 9'h0db;

   // configuration register indexes
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 11'd1024;

   typedef enum logic [CLASS_W-1:0] {
      CLASS_NONE     = 3'd0,
      CLASS_ENDPOINT = 3'd1,
      CLASS_STRAIGHT = 3'd2,
      CLASS_CORNER   = 3'd3,
      CLASS_JUNCTION = 3'd4
   } class_type;

endpackage

FILE: hw/rtl/spc3_ram.sv
module spc3_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/skeleton_pixel_classifier_3x3.sv
// channel  | direction | tdata (low bit up)                       | tuser          | tlast
// ---------+-----------+------------------------------------------+----------------+--------------
// req_     | in        | pixel_value[31:0]                        | start_of_frame | -
// rsp_     | out       | center_x[9:0] center_y[9:0] class[2:0] 0 | -              | last_of_frame
// csr_     | in        | write enable, register index, write data | -              | -
//
// one pixel transfer per clock unless a held result stalls it; each pixel is registered in stage one
// and then in the result register, which loads as a pixel with a result leaves stage one
// the line store read (one ram port, registered) sets the two-stage depth
// reset is synchronous and clears position, window, sizes and the handshake state;
// the line store is not cleared
// a held result stalls stage one only while it holds a pixel that produces a result; pixels without one drain past it
module skeleton_pixel_classifier_3x3 #(
   parameter int MAX_WIDTH  = spc3_pkg::MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = spc3_pkg::MAX_HEIGHT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // pixel stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [spc3_pkg::REQ_TDATA_W-1:0]  req_tdata,  // pixel_value[31:0]
   input  logic                              req_tuser,  // start_of_frame
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [spc3_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // center_x, center_y, pixel_class, pad
   output logic                              rsp_tlast,  // last_of_frame
   // configuration writes
   input  logic                              csr_we,
   input  logic [spc3_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [spc3_pkg::CFG_W-1:0]        csr_wdata
);

   // column index, column count, row index and row count widths
   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int RW    = $clog2(MAX_HEIGHT);
   localparam int RHW   = $clog2(MAX_HEIGHT + 1);
   localparam int CMPWX = (spc3_pkg::CFG_W > CW)  ? spc3_pkg::CFG_W : CW;
   localparam int CMPWY = (spc3_pkg::CFG_W > RHW) ? spc3_pkg::CFG_W : RHW;
   localparam int PADW  = spc3_pkg::RSP_TDATA_W - 2 * spc3_pkg::COORD_W - spc3_pkg::CLASS_W;

   // configuration registers
   logic [spc3_pkg::CFG_W-1:0] width_cfg_ff, height_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= spc3_pkg::CFG_SIZE_RESET;
         height_cfg_ff <= spc3_pkg::CFG_SIZE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            spc3_pkg::CSR_IMAGE_WIDTH:  width_cfg_ff  <= csr_wdata;
            spc3_pkg::CSR_IMAGE_HEIGHT: height_cfg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sizes clamped to three .. maximum
   logic [CMPWX-1:0] width_raw;
   logic [CMPWY-1:0] height_raw;
   logic [CW-1:0]    width_eff;
   logic [RHW-1:0]   height_eff;

   always_comb begin
      width_raw  = CMPWX'(width_cfg_ff);
      height_raw = CMPWY'(height_cfg_ff);
      if (width_raw < CMPWX'(3)) begin
         width_eff = CW'(3);
      end else if (width_raw > CMPWX'(MAX_WIDTH)) begin
         width_eff = CW'(MAX_WIDTH);
      end else begin
         width_eff = CW'(width_raw);
      end
      if (height_raw < CMPWY'(3)) begin
         height_eff = RHW'(3);
      end else if (height_raw > CMPWY'(MAX_HEIGHT)) begin
         height_eff = RHW'(MAX_HEIGHT);
      end else begin
         height_eff = RHW'(height_raw);
      end
   end

   // handshake control
   logic req_xfer;
   logic s1_fire;
   logic s1_valid_ff, s1_valid_in;
   logic s1_res_ff;

   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_xfer   = req_tvalid && req_tready;
   assign s1_fire    = s1_valid_ff && (!s1_res_ff || !rsp_tvalid || rsp_tready);

   // raster position of the incoming pixel
   logic [AW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [AW-1:0]  col_sel, pos_x;
   logic [RW-1:0]  row_sel, pos_y;
   logic [RHW-1:0] row_step;
   logic [CW-1:0]  x_inc;
   logic [RHW-1:0] y_inc;
   logic           pos_last, pos_res;

   always_comb begin
      // start of frame forces the origin
      col_sel = req_tuser ? '0 : col_ff;
      row_sel = req_tuser ? '0 : row_ff;
      // a column past a shrunk width moves to the next row
      row_step = RHW'(row_sel);
      pos_x    = col_sel;
      if (CW'(col_sel) >= width_eff) begin
         pos_x    = '0;
         row_step = RHW'(row_sel) + RHW'(1);
      end
      pos_y = (row_step >= height_eff) ? '0 : RW'(row_step);

      // advance with wrap at row and frame end
      x_inc  = CW'(pos_x) + CW'(1);
      y_inc  = RHW'(pos_y) + RHW'(1);
      col_in = AW'(x_inc);
      row_in = pos_y;
      if (x_inc >= width_eff) begin
         col_in = '0;
         row_in = (y_inc >= height_eff) ? '0 : RW'(y_inc);
      end

      pos_last = (CW'(pos_x) == width_eff - CW'(1)) && (RHW'(pos_y) == height_eff - RHW'(1));
      pos_res  = (pos_x >= AW'(2)) && (pos_y >= RW'(2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_xfer) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line store: bit 1 previous row, bit 0 the row before it
   logic [1:0] store_rd;
   logic [1:0] store_eff;
   logic [1:0] store_wr;
   logic       s1_ink_ff;
   logic [AW-1:0] s1_x_ff;
   logic [RW-1:0] s1_y_ff;
   logic       s1_last_ff;
   logic       fwd_ff;
   logic [1:0] fwd_data_ff;

   assign store_eff = fwd_ff ? fwd_data_ff : store_rd;
   assign store_wr  = {s1_ink_ff, store_eff[1]};

   spc3_ram #(
      .WIDTH (2),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_x_ff),
      .wr_data (store_wr),
      .rd_en   (req_xfer),
      .rd_addr (pos_x),
      .rd_data (store_rd)
   );

   // stage one: pixel waiting for its line store read
   assign s1_valid_in = req_xfer ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_ink_ff   <= (req_tdata != spc3_pkg::WHITE_PIXEL);
         s1_x_ff     <= pos_x;
         s1_y_ff     <= pos_y;
         s1_last_ff  <= pos_last;
         s1_res_ff   <= pos_res;
         // same column written at this edge: the read sees stale data
         fwd_ff      <= s1_fire && (s1_x_ff == pos_x);
         fwd_data_ff <= store_wr;
      end
   end

   // window update and classification
   logic [8:0] win_ff, win_in;
   logic [3:0] nbr_count;
   logic       straight;
   spc3_pkg::class_type pix_class;

   always_comb begin
      win_in = ((win_ff >> 1) & spc3_pkg::WIN_KEEP_MASK)
             | {s1_ink_ff, 2'b00, store_eff[1], 2'b00, store_eff[0], 2'b00};
      nbr_count = 4'($countones({win_in[8:5], win_in[3:0]}));
      straight  = (win_in[0] && win_in[8]) || (win_in[2] && win_in[6])
               || (win_in[1] && win_in[7]) || (win_in[3] && win_in[5]);
      pix_class = spc3_pkg::CLASS_NONE;
      if (win_in[4]) begin
         if (nbr_count == 4'd1) begin
            pix_class = spc3_pkg::CLASS_ENDPOINT;
         end else if (nbr_count == 4'd2) begin
            pix_class = straight ? spc3_pkg::CLASS_STRAIGHT : spc3_pkg::CLASS_CORNER;
         end else if (nbr_count >= 4'd3) begin
            pix_class = spc3_pkg::CLASS_JUNCTION;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_fire) begin
         win_ff <= win_in;
      end
   end

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_load;
   logic [spc3_pkg::COORD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic [spc3_pkg::CLASS_W-1:0] rsp_class_ff;
   logic rsp_last_ff;

   assign rsp_load     = s1_fire && s1_res_ff;
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result names the centre, one column and one row back
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_x_ff     <= spc3_pkg::COORD_W'(s1_x_ff - AW'(1));
         rsp_y_ff     <= spc3_pkg::COORD_W'(s1_y_ff - RW'(1));
         rsp_class_ff <= pix_class;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PADW{1'b0}}, rsp_class_ff, rsp_y_ff, rsp_x_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // a pixel with a result leaving stage one must show up at the output
   a_result_lands: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_res_ff |=> rsp_tvalid)
      else $error("classified pixel did not reach the result register");

   // class code stays within the defined set
   a_class_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[22:20] <= 3'd4))
      else $error("result carries an undefined class code");

   // a pixel without a result in stage one never blocks the input
   a_stage_flow: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_res_ff |-> req_tready)
      else $error("pixel without a result blocked the input");
`endif

endmodule

FILE: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int RANDOM_PIXELS   = 580;
   localparam int SETTLE_CYCLES   = 10;   // extra wait after the last expected result, as margin
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int REPORT_LIMIT    = 10;
   localparam int DIRECTED_LEN    = 25;
   localparam int TALL_RUN        = 240;
   localparam int WIDE_RUN        = 40;
   localparam int NARROW_W        = 10;

   // one classified centre, as carried by a result transfer
   typedef struct packed {
      logic [spc3_pkg::COORD_W-1:0] x;
      logic [spc3_pkg::COORD_W-1:0] y;
      spc3_pkg::class_type          cls;
      logic                         frame_end;
   } centre_type;

   // one row of the directed table; hand_checked rows carry a typed-in result
   typedef struct packed {
      logic [spc3_pkg::PIXEL_W-1:0] pixel;
      logic                         sof;
      logic                         hand_checked;
      centre_type                   result;
   } directed_row_type;

   localparam logic [spc3_pkg::PIXEL_W-1:0] BG = spc3_pkg::WHITE_PIXEL;
   localparam centre_type NO_CENTRE = '{10'd0, 10'd0, spc3_pkg::CLASS_NONE, 1'b0};

   // 7x3 frame, ink map (1 = ink):
   //   row 0: 1 0 0 0 0 0 0
   //   row 1: 0 1 0 1 1 1 1
   //   row 2: 0 0 0 1 0 0 0
   // centres of row 1 read endpoint, none, corner, junction, straight body;
   // four pixels of the next frame follow without a frame marker (self wrap)
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_LEN] = '{
      '{32'h0000_0000, 1'b1, 1'b0, NO_CENTRE},
      '{BG,            1'b0, 1'b0, NO_CENTRE},
      '{BG,            1'b0, 1'b0, NO_CENTRE},
      '{BG,            1'b0, 1'b0, NO_CENTRE},
      '{BG,            1'b0, 1'b0, NO_CENTRE},
      '{BG,            1'b0, 1'b0, NO_CENTRE},
      '{BG,            1'b0, 1'b0, NO_CENTRE},
      '{BG,            1'b0, 1'b0, NO_CENTRE},
      '{32'hFFFF_FFFE, 1'b0, 1'b0, NO_CENTRE},
      '{BG,            1'b0, 1'b0, NO_CENTRE},
      '{32'h7FFF_FFFF, 1'b0, 1'b0, NO_CENTRE},
      '{32'h8000_0000, 1'b0, 1'b0, NO_CENTRE},
      '{32'h1234_5678, 1'b0, 1'b0, NO_CENTRE},
      '{32'hFFFE_FFFF, 1'b0, 1'b0, NO_CENTRE},
      '{BG,            1'b0, 1'b0, NO_CENTRE},
      '{BG,            1'b0, 1'b0, NO_CENTRE},
      '{BG,            1'b0, 1'b1, '{10'd1, 10'd1, spc3_pkg::CLASS_ENDPOINT, 1'b0}},
      '{32'hDEAD_BEEF, 1'b0, 1'b1, '{10'd2, 10'd1, spc3_pkg::CLASS_NONE,     1'b0}},
      '{BG,            1'b0, 1'b1, '{10'd3, 10'd1, spc3_pkg::CLASS_CORNER,   1'b0}},
      '{BG,            1'b0, 1'b1, '{10'd4, 10'd1, spc3_pkg::CLASS_JUNCTION, 1'b0}},
      '{BG,            1'b0, 1'b1, '{10'd5, 10'd1, spc3_pkg::CLASS_STRAIGHT, 1'b1}},
      '{32'h0000_0001, 1'b0, 1'b0, NO_CENTRE},
      '{BG,            1'b0, 1'b0, NO_CENTRE},
      '{32'hA5A5_A5A5, 1'b0, 1'b0, NO_CENTRE},
      '{BG,            1'b0, 1'b0, NO_CENTRE}
   };

   logic                               clock      = 1'b0;
   logic                               reset      = 1'b1;
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [spc3_pkg::REQ_TDATA_W-1:0]   req_tdata  = '0;
   logic                               req_tuser  = 1'b0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [spc3_pkg::RSP_TDATA_W-1:0]   rsp_tdata;
   logic                               rsp_tlast;
   logic                               csr_we     = 1'b0;
   logic [spc3_pkg::CSR_INDEX_W-1:0]   csr_index  = spc3_pkg::CSR_IMAGE_WIDTH;
   logic [spc3_pkg::CFG_W-1:0]         csr_wdata  = '0;

   // shared between the stimulus and the result sink
   centre_type  expected_centres [$];
   int unsigned error_count      = 0;
   int unsigned cycle_count      = 0;
   bit          steady_flow      = 1'b0;  // no idling on either side
   bit          hold_off_pending = 1'b0;  // one long stall of the result channel

   // predictor state: own copy of the line stores, window, position and sizes
   bit                          line_prev  [spc3_pkg::MAX_WIDTH_DEFAULT];
   bit                          line_older [spc3_pkg::MAX_WIDTH_DEFAULT];
   logic [8:0]                  window     = '0;
   int unsigned                 col_pos    = 0;
   int unsigned                 row_pos    = 0;
   logic [spc3_pkg::CFG_W-1:0]  width_reg  = spc3_pkg::CFG_SIZE_RESET;
   logic [spc3_pkg::CFG_W-1:0]  height_reg = spc3_pkg::CFG_SIZE_RESET;

   skeleton_pixel_classifier_3x3 DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // pixel_value[31:0]
      .req_tuser  (req_tuser),   // start_of_frame
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // center_x[9:0], center_y[19:10], pixel_class[22:20], pad
      .rsp_tlast  (rsp_tlast),   // last_of_frame
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // sizes outside 3..maximum behave as the nearest bound
   function automatic int unsigned clamp_size(input logic [spc3_pkg::CFG_W-1:0] v,
                                              input int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic spc3_pkg::class_type class_of(input logic [8:0] win);
      int n;
      n = $countones(win) - int'(win[4]);
      if (!win[4] || n == 0) return spc3_pkg::CLASS_NONE;
      if (n == 1) return spc3_pkg::CLASS_ENDPOINT;
      if (n == 2) begin
         // opposite pairs through the centre
         if ((win[0] && win[8]) || (win[2] && win[6]) || (win[1] && win[7]) ||
             (win[3] && win[5]))
            return spc3_pkg::CLASS_STRAIGHT;
         return spc3_pkg::CLASS_CORNER;
      end
      return spc3_pkg::CLASS_JUNCTION;
   endfunction

   // advances the predictor by one pixel; returns 1 when a centre is classed
   function automatic bit classify_pixel(input logic [spc3_pkg::PIXEL_W-1:0] pixel,
                                         input logic sof, output centre_type res);
      int unsigned w, h, x, y;
      bit ink, older, prev;
      w = clamp_size(width_reg, spc3_pkg::MAX_WIDTH_DEFAULT);
      h = clamp_size(height_reg, spc3_pkg::MAX_HEIGHT_DEFAULT);
      ink = (pixel != spc3_pkg::WHITE_PIXEL);
      if (sof) begin
         col_pos = 0;
         row_pos = 0;
      end
      // position left beyond a shrunk size
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      x = col_pos;
      y = row_pos;
      older = line_older[x];
      prev  = line_prev[x];
      // columns shift towards the oldest, the new column enters at the top
      window = {ink, window[8:7], prev, window[5:4], older, window[2:1]};
      line_older[x] = prev;
      line_prev[x]  = ink;
      res.x         = spc3_pkg::COORD_W'(x - 1);
      res.y         = spc3_pkg::COORD_W'(y - 1);
      res.cls       = class_of(window);
      res.frame_end = (x == w - 1) && (y == h - 1);
      col_pos = x + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = y + 1;
         if (row_pos >= h) row_pos = 0;
      end
      return (x >= 2) && (y >= 2);
   endfunction

   function automatic logic [spc3_pkg::PIXEL_W-1:0] random_pixel(input int unsigned ink_pct);
      logic [spc3_pkg::PIXEL_W-1:0] p;
      if ($urandom_range(0, 99) >= ink_pct) return spc3_pkg::WHITE_PIXEL;
      // ink one bit away from white now and then
      if ($urandom_range(0, 9) == 0)
         return spc3_pkg::WHITE_PIXEL ^
                (spc3_pkg::PIXEL_W'(1) << $urandom_range(0, spc3_pkg::PIXEL_W - 1));
      p = $urandom;
      return (p == spc3_pkg::WHITE_PIXEL) ? (p ^ spc3_pkg::PIXEL_W'(1)) : p;
   endfunction

   // entered and left at a falling edge; valid stays high into the next pixel
   task automatic send_pixel(input logic [spc3_pkg::PIXEL_W-1:0] pixel, input logic sof,
                             input logic hand_checked = 1'b0,
                             input centre_type typed_res = NO_CENTRE);
      int unsigned gap;
      centre_type  res;
      bit          produced;
      gap = steady_flow ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pixel;
      req_tuser  <= sof;
      do @(posedge clock); while (!req_tready);
      produced = classify_pixel(pixel, sof, res);
      if (hand_checked) expected_centres.push_back(typed_res);
      else if (produced) expected_centres.push_back(res);
      @(negedge clock);
   endtask

   // stop offering, wait for every expected result, then let the pipe empty
   task automatic settle();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (expected_centres.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // both size registers, back to back, only while idle
   task automatic program_frame_size(input logic [spc3_pkg::CFG_W-1:0] w,
                                     input logic [spc3_pkg::CFG_W-1:0] h);
      csr_we    <= 1'b1;
      csr_index <= spc3_pkg::CSR_IMAGE_WIDTH;
      csr_wdata <= w;
      @(negedge clock);
      csr_index <= spc3_pkg::CSR_IMAGE_HEIGHT;
      csr_wdata <= h;
      @(negedge clock);
      csr_we     <= 1'b0;
      width_reg  = w;
      height_reg = h;
   endtask

   // a run of pixels with random ink, a frame marker on the first one only if asked
   task automatic stream_run(input int unsigned count, input bit first_sof);
      int unsigned ink_pct;
      ink_pct = $urandom_range(15, 85);
      for (int unsigned i = 0; i < count; i++)
         send_pixel(random_pixel(ink_pct), (i == 0) ? first_sof : 1'b0);
   endtask

   // whole frames with random ink, the last one optionally cut short;
   // a stray frame marker now and then breaks a frame
   task automatic stream_frames(input int unsigned frames, input bit first_sof,
                                input bit cut_last, output int unsigned sent);
      int unsigned len, ink_pct;
      bit          sof;
      sent = 0;
      for (int unsigned f = 0; f < frames; f++) begin
         ink_pct = $urandom_range(15, 85);
         len = clamp_size(width_reg, spc3_pkg::MAX_WIDTH_DEFAULT) *
               clamp_size(height_reg, spc3_pkg::MAX_HEIGHT_DEFAULT);
         if (cut_last && f == frames - 1) len = $urandom_range(1, len - 1);
         for (int unsigned i = 0; i < len; i++) begin
            if (i == 0) sof = (f == 0) ? first_sof : ($urandom_range(0, 3) != 0);
            else sof = ($urandom_range(0, 399) == 0);
            send_pixel(random_pixel(ink_pct), sof);
            sent++;
            // sender pauses mid-frame until the results catch up
            if ($urandom_range(0, 299) == 0) settle();
         end
      end
   endtask

   // result sink: random stalls, one long hold-off on request
   initial begin : result_sink
      int unsigned stall;
      centre_type  want, got;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_off_pending) begin
            stall = HOLD_OFF_CYCLES;
            hold_off_pending = 1'b0;
         end else begin
            stall = steady_flow ? 0 : $urandom_range(0, 9);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got.x         = rsp_tdata[spc3_pkg::COORD_W-1:0];
         got.y         = rsp_tdata[2*spc3_pkg::COORD_W-1:spc3_pkg::COORD_W];
         got.cls       = spc3_pkg::class_type'(rsp_tdata[2*spc3_pkg::COORD_W +:
                                                         spc3_pkg::CLASS_W]);
         got.frame_end = rsp_tlast;
         if (expected_centres.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected result transfer: x=%0d y=%0d class=%0d last=%0b",
                        got.x, got.y, got.cls, got.frame_end);
         end else begin
            want = expected_centres.pop_front();
            if (got.x !== want.x || got.y !== want.y || got.cls !== want.cls ||
                got.frame_end !== want.frame_end) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("bad result: expected x=%0d y=%0d class=%0d last=%0b, got x=%0d y=%0d class=%0d last=%0b",
                           want.x, want.y, want.cls, want.frame_end,
                           got.x, got.y, got.cls, got.frame_end);
            end
         end
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int unsigned                sent, random_sent;
      logic [spc3_pkg::CFG_W-1:0] new_w, new_h;
      bit                         first_sof;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: hand-built frame covering every class and the self wrap
      program_frame_size(spc3_pkg::CFG_W'(7), spc3_pkg::CFG_W'(3));
      for (int i = 0; i < DIRECTED_LEN; i++)
         send_pixel(DIRECTED_ROWS[i].pixel, DIRECTED_ROWS[i].sof,
                    DIRECTED_ROWS[i].hand_checked, DIRECTED_ROWS[i].result);
      settle();

      // receiver holds off while the sender keeps offering, so the block backs up
      program_frame_size(spc3_pkg::CFG_W'(24), spc3_pkg::CFG_W'(6));
      hold_off_pending = 1'b1;
      stream_frames(1, 1'b1, 1'b0, sent);
      settle();

      // narrowest line (clamped from zero) down part of the tallest frame (clamped)
      program_frame_size(spc3_pkg::CFG_W'(0), spc3_pkg::CFG_W'(2047));
      stream_run(TALL_RUN, 1'b1);
      settle();

      // widest line (clamped from the top code) for part of a row; a narrower width
      // then moves the position to the next row and the frame ends at that width
      program_frame_size(spc3_pkg::CFG_W'(2047), spc3_pkg::CFG_W'(3));
      stream_run(WIDE_RUN, 1'b1);
      settle();
      program_frame_size(spc3_pkg::CFG_W'(NARROW_W), spc3_pkg::CFG_W'(3));
      stream_run(2 * NARROW_W, 1'b0);
      settle();

      // random phases: small sizes, some out of range, some frames cut short so
      // the next size applies mid-frame
      random_sent = 0;
      while (random_sent < RANDOM_PIXELS) begin
         case ($urandom_range(0, 9))
            0:       new_w = spc3_pkg::CFG_W'($urandom_range(0, 2));
            1:       new_w = spc3_pkg::CFG_W'($urandom_range(13, 40));
            default: new_w = spc3_pkg::CFG_W'($urandom_range(3, 12));
         endcase
         if ($urandom_range(0, 9) == 0) new_h = spc3_pkg::CFG_W'($urandom_range(0, 2));
         else new_h = spc3_pkg::CFG_W'($urandom_range(3, 8));
         // a wider line mid-frame would read line store entries never written:
         // restart the frame in that case
         first_sof = ($urandom_range(0, 1) == 1);
         if (clamp_size(new_w, spc3_pkg::MAX_WIDTH_DEFAULT) >
             clamp_size(width_reg, spc3_pkg::MAX_WIDTH_DEFAULT) &&
             (col_pos != 0 || row_pos != 0))
            first_sof = 1'b1;
         steady_flow = ($urandom_range(0, 3) == 0);
         program_frame_size(new_w, new_h);
         stream_frames($urandom_range(1, 3), first_sof, $urandom_range(0, 2) == 0, sent);
         random_sent += sent;
         settle();
      end

      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
